@@ hdl/frlpm_pkg.sv @@
// frlpm_pkg: shared types, codes and constants of the flash ring log page manager
// no dependencies; imported by frlpm_page_store and flash_ring_log_page_manager_unit
`timescale 1ns / 1ps

package frlpm_pkg;

  localparam int unsigned SECTOR_COUNT_DEF     = 16;
  localparam int unsigned PAGES_PER_SECTOR_DEF = 16;

  localparam logic [31:0] EMPTY_WORD    = 32'hFFFF_FFFF;
  localparam logic [15:0] MIN_GAP_RESET = 16'd250;

  // input kinds
  localparam logic [2:0] KIND_SCAN   = 3'd0;
  localparam logic [2:0] KIND_EVENT  = 3'd1;
  localparam logic [2:0] KIND_BOOT   = 3'd2;
  localparam logic [2:0] KIND_LOOKUP = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic CFG_LOG_AVAILABLE = 1'b0;
  localparam logic CFG_MIN_GAP_MS    = 1'b1;

  typedef enum logic [1:0] {
    OP_ERASE   = 2'd0,
    OP_PROGRAM = 2'd1,
    OP_STATUS  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_UNAVAIL   = 3'd1,
    STAT_RATE      = 3'd2,
    STAT_FAIL      = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_RANGE     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APP,
    S_DIV,
    S_MID,
    S_DIRTY,
    S_WIPE,
    S_PROG,
    S_COMMIT,
    S_FAIL,
    S_LOOK,
    S_CLR,
    S_CLR_WIPE
  } state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  page_index;
    logic [31:0] seq_word;
    logic [31:0] time_ms;
    logic [7:0]  nth_newest;
    logic        erase_ok;
    logic        program_ok;
  } item_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  target;
    logic [31:0] seq_value;
    status_e     status;
    logic [8:0]  valid_pages;
    logic        last;
  } result_t;

endpackage

@@ hdl/frlpm_page_store.sv @@
// frlpm_page_store: per-page sequence word memory, one write and one registered read port
// depends on frlpm_pkg
`timescale 1ns / 1ps

module frlpm_page_store
  import frlpm_pkg::*;
#(
  parameter int unsigned DEPTH = SECTOR_COUNT_DEF * PAGES_PER_SECTOR_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/flash_ring_log_page_manager_unit.sv @@
// flash_ring_log_page_manager_unit: top level, sequencer around the page word memory
// depends on frlpm_pkg and frlpm_page_store
`timescale 1ns / 1ps

// Flash ring log page manager. An item is taken when start is high and busy is
// low; busy stays high until the final status transfer of that item. Each
// result is shown for exactly one cycle with res_strobe_o and the receiver
// cannot stall it; an item gives zero or more command transfers (erase, program)
// and then one status transfer with last set. Scans, lookups and dirty checks
// read the page word memory through its single read port, one page per cycle;
// wipes go through the write port. An append splits the write page into sector
// and offset by repeated subtraction, at a sector start checks the sector for
// used pages and wipes it after a good erase; a clear erases, then wipes all.
// Quick answers (unavailable, rate limited, out of range) come from decode.
// The page memory is not cleared at reset: scan every page before using it.
// Configuration writes are taken at any time but are meant for idle periods.

module flash_ring_log_page_manager_unit
  import frlpm_pkg::*;
#(
  parameter int unsigned SECTOR_COUNT     = SECTOR_COUNT_DEF,
  parameter int unsigned PAGES_PER_SECTOR = PAGES_PER_SECTOR_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   in_i,
  input  logic    cfg_we_i,
  input  logic    cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic    res_strobe_o,
  output result_t res_o
);

  localparam int unsigned PAGE_COUNT = SECTOR_COUNT * PAGES_PER_SECTOR;
  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned SW = $clog2(SECTOR_COUNT);
  localparam int unsigned CW = $clog2(PAGE_COUNT + 1);
  localparam int unsigned NW = $clog2(PAGES_PER_SECTOR + 1);

  // configuration
  logic        avail_q;
  logic [15:0] min_gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q   <= 1'b0;
      min_gap_q <= MIN_GAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOG_AVAILABLE: avail_q   <= cfg_data_i[0];
        CFG_MIN_GAP_MS:    min_gap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e        state_q, state_d;
  item_t         item_q;
  logic [31:0]   highest_q, highest_d;
  logic [PW-1:0] wp_q, wp_d;
  logic [8:0]    valid_q, valid_d;
  logic [31:0]   last_time_q, last_time_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [SW-1:0] sec_q, sec_d;
  logic [NW-1:0] ne_q, ne_d;
  logic [31:0]   want_q, want_d;

  // memory port and read pipeline
  logic          rd_req, rd_vld_q;
  logic [PW-1:0] raddr, rd_tag_q;
  logic [31:0]   rdata;
  logic          we;
  logic [PW-1:0] waddr;
  logic [31:0]   wdata;

  // result transfer
  logic          emit;
  op_e           em_op;
  logic [7:0]    em_tgt;
  logic [31:0]   em_seq;
  status_e       em_stat;
  logic          em_last;
  logic          accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  frlpm_page_store #(
    .DEPTH(PAGE_COUNT)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    highest_d   = highest_q;
    wp_d        = wp_q;
    valid_d     = valid_q;
    last_time_d = last_time_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    sec_d       = sec_q;
    ne_d        = ne_q;
    want_d      = want_q;
    rd_req      = 1'b0;
    raddr       = wp_q;
    we          = 1'b0;
    waddr       = wp_q;
    wdata       = EMPTY_WORD;
    emit        = 1'b0;
    em_op       = OP_STATUS;
    em_tgt      = '0;
    em_seq      = '0;
    em_stat     = STAT_DONE;
    em_last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (item_q.kind == KIND_SCAN) begin
          if (32'(item_q.page_index) >= 32'(PAGE_COUNT)) begin
            emit    = 1'b1;
            em_stat = STAT_RANGE;
            em_last = 1'b1;
            state_d = S_IDLE;
          end else begin
            rd_req  = 1'b1;
            raddr   = PW'(item_q.page_index);
            state_d = S_SCAN;
          end
        end else if (item_q.kind > KIND_CLEAR) begin
          emit    = 1'b1;
          em_stat = STAT_RANGE;
          em_last = 1'b1;
          state_d = S_IDLE;
        end else if (!avail_q) begin
          emit    = 1'b1;
          em_stat = STAT_UNAVAIL;
          em_last = 1'b1;
          state_d = S_IDLE;
        end else begin
          case (item_q.kind)
            KIND_EVENT: begin
              // rate limit, zero stamp means never appended
              if (last_time_q != '0 &&
                  (item_q.time_ms - last_time_q) < 32'(min_gap_q)) begin
                emit    = 1'b1;
                em_stat = STAT_RATE;
                em_last = 1'b1;
                state_d = S_IDLE;
              end else begin
                last_time_d = (item_q.time_ms != '0) ? item_q.time_ms : 32'd1;
                state_d     = S_APP;
              end
            end
            KIND_BOOT: state_d = S_APP;
            KIND_LOOKUP: begin
              if ({1'b0, item_q.nth_newest} >= valid_q) begin
                emit    = 1'b1;
                em_stat = STAT_RANGE;
                em_last = 1'b1;
                state_d = S_IDLE;
              end else begin
                want_d  = highest_q - 32'(item_q.nth_newest);
                cnt_d   = '0;
                state_d = S_LOOK;
              end
            end
            default: begin
              sec_d   = '0;
              state_d = S_CLR;
            end
          endcase
        end
      end

      S_SCAN: begin
        // old word of the page is on the read port now
        valid_d = valid_q;
        if (rdata != EMPTY_WORD && valid_q != '0) begin
          valid_d = valid_q - 9'd1;
        end
        if (item_q.seq_word != EMPTY_WORD) begin
          valid_d = valid_d + 9'd1;
          if (item_q.seq_word > highest_q) begin
            highest_d = item_q.seq_word;
            wp_d = (32'(item_q.page_index) == 32'(PAGE_COUNT - 1)) ? '0
                 : PW'(item_q.page_index) + PW'(1);
          end
        end
        we      = 1'b1;
        waddr   = PW'(item_q.page_index);
        wdata   = item_q.seq_word;
        emit    = 1'b1;
        em_tgt  = item_q.page_index;
        em_seq  = item_q.seq_word;
        em_last = 1'b1;
        state_d = S_IDLE;
      end

      S_APP: begin
        // a failed append still uses up a sequence number
        highest_d = highest_q + 32'd1;
        rem_d     = wp_q;
        sec_d     = '0;
        state_d   = S_DIV;
      end

      S_DIV: begin
        // split write page into sector and offset by repeated subtraction
        if (rem_q >= PW'(PAGES_PER_SECTOR)) begin
          rem_d = rem_q - PW'(PAGES_PER_SECTOR);
          sec_d = sec_q + SW'(1);
        end else if (rem_q != '0) begin
          rd_req  = 1'b1;
          raddr   = wp_q;
          state_d = S_MID;
        end else begin
          cnt_d   = '0;
          ne_d    = '0;
          state_d = S_DIRTY;
        end
      end

      S_MID: begin
        // torn page in mid-sector: skip to the next sector boundary
        if (rdata != EMPTY_WORD) begin
          if (sec_q == SW'(SECTOR_COUNT - 1)) begin
            wp_d  = '0;
            sec_d = '0;
          end else begin
            wp_d  = wp_q - rem_q + PW'(PAGES_PER_SECTOR);
            sec_d = sec_q + SW'(1);
          end
          cnt_d   = '0;
          ne_d    = '0;
          state_d = S_DIRTY;
        end else begin
          state_d = S_PROG;
        end
      end

      S_DIRTY: begin
        if (cnt_q < CW'(PAGES_PER_SECTOR)) begin
          rd_req = 1'b1;
          raddr  = wp_q + PW'(cnt_q);
          cnt_d  = cnt_q + CW'(1);
        end
        if (rd_vld_q && rdata != EMPTY_WORD) begin
          ne_d = ne_q + NW'(1);
        end
        if (cnt_q == CW'(PAGES_PER_SECTOR) && !rd_vld_q) begin
          if (ne_q != '0) begin
            emit   = 1'b1;
            em_op  = OP_ERASE;
            em_tgt = 8'(sec_q);
            cnt_d  = '0;
            state_d = item_q.erase_ok ? S_WIPE : S_FAIL;
          end else begin
            state_d = S_PROG;
          end
        end
      end

      S_WIPE: begin
        we    = 1'b1;
        waddr = wp_q + PW'(cnt_q);
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PAGES_PER_SECTOR - 1)) begin
          valid_d = (valid_q >= 9'(ne_q)) ? valid_q - 9'(ne_q) : '0;
          state_d = S_PROG;
        end
      end

      S_PROG: begin
        emit    = 1'b1;
        em_op   = OP_PROGRAM;
        em_tgt  = 8'(wp_q);
        em_seq  = highest_q;
        state_d = item_q.program_ok ? S_COMMIT : S_FAIL;
      end

      S_COMMIT: begin
        we      = 1'b1;
        waddr   = wp_q;
        wdata   = highest_q;
        valid_d = valid_q + 9'd1;
        wp_d    = (wp_q == PW'(PAGE_COUNT - 1)) ? '0 : wp_q + PW'(1);
        emit    = 1'b1;
        em_tgt  = 8'(wp_q);
        em_seq  = highest_q;
        em_last = 1'b1;
        state_d = S_IDLE;
      end

      S_FAIL: begin
        emit    = 1'b1;
        em_stat = STAT_FAIL;
        em_last = 1'b1;
        if (item_q.kind != KIND_CLEAR) begin
          em_tgt = 8'(wp_q);
          em_seq = highest_q;
        end
        state_d = S_IDLE;
      end

      S_LOOK: begin
        if (cnt_q < CW'(PAGE_COUNT)) begin
          rd_req = 1'b1;
          raddr  = PW'(cnt_q);
          cnt_d  = cnt_q + CW'(1);
        end
        if (rd_vld_q && rdata == want_q) begin
          // lowest matching page wins
          emit    = 1'b1;
          em_tgt  = 8'(rd_tag_q);
          em_seq  = want_q;
          em_last = 1'b1;
          state_d = S_IDLE;
        end else if (cnt_q == CW'(PAGE_COUNT) && !rd_vld_q) begin
          emit    = 1'b1;
          em_seq  = want_q;
          em_stat = STAT_NOT_FOUND;
          em_last = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_CLR: begin
        emit   = 1'b1;
        em_op  = OP_ERASE;
        em_tgt = 8'(sec_q);
        if (!item_q.erase_ok) begin
          state_d = S_FAIL;
        end else if (sec_q == SW'(SECTOR_COUNT - 1)) begin
          cnt_d   = '0;
          state_d = S_CLR_WIPE;
        end else begin
          sec_d = sec_q + SW'(1);
        end
      end

      S_CLR_WIPE: begin
        we    = 1'b1;
        waddr = PW'(cnt_q);
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(PAGE_COUNT - 1)) begin
          highest_d = '0;
          wp_d      = '0;
          valid_d   = '0;
          emit      = 1'b1;
          em_last   = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      highest_q   <= '0;
      wp_q        <= '0;
      valid_q     <= '0;
      last_time_q <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      sec_q       <= '0;
      ne_q        <= '0;
      rd_vld_q    <= 1'b0;
      res_strobe_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      highest_q   <= highest_d;
      wp_q        <= wp_d;
      valid_q     <= valid_d;
      last_time_q <= last_time_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      sec_q       <= sec_d;
      ne_q        <= ne_d;
      rd_vld_q    <= rd_req;
      res_strobe_o <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
    end
    want_q   <= want_d;
    rd_tag_q <= raddr;
    if (emit) begin
      res_o.op          <= em_op;
      res_o.target      <= em_tgt;
      res_o.seq_value   <= em_seq;
      res_o.status      <= em_stat;
      res_o.valid_pages <= valid_d;
      res_o.last        <= em_last;
    end
  end

`ifndef ASSERT_OFF
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.last |-> !busy)
    else $error("final transfer while still busy");

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> busy)
    else $error("command transfer without a final one pending");

  a_cmd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> res_o.status == STAT_DONE)
    else $error("command transfer carries a status");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("item taken but sequencer idle");
`endif

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for flash_ring_log_page_manager_unit
// depends on frlpm_pkg and the unit; directed tests, then random traffic against an
// internal prediction of the page ring
`timescale 1ns / 1ps

module tb_top;
  import frlpm_pkg::*;

  localparam int unsigned PAGES   = SECTOR_COUNT_DEF * PAGES_PER_SECTOR_DEF;
  localparam int unsigned PPS     = PAGES_PER_SECTOR_DEF;
  localparam int unsigned SECTORS = SECTOR_COUNT_DEF;
  localparam int unsigned STALL_LIMIT = 3000;   // cycles with no transfer at all
  localparam int unsigned SETTLE      = 300;    // longest item is a clear

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       in_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        res_strobe_o;
  result_t     res_o;

  flash_ring_log_page_manager_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predicted copy of the ring state and its registers
  logic [31:0] ring_word [PAGES];
  logic [31:0] top_seq;
  int unsigned wr_page;
  int unsigned live_pages;
  logic [31:0] last_event_ms;
  logic        log_on;
  logic [15:0] gap_ms;

  result_t     pending_results[$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  bit          idle_enabled;
  logic [31:0] clock_ms;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic push_result(op_e op, int unsigned tgt, logic [31:0] sq, status_e st,
                             bit fin);
    result_t r;
    r.op          = op;
    r.target      = tgt[7:0];
    r.seq_value   = sq;
    r.status      = st;
    r.valid_pages = live_pages[8:0];
    r.last        = fin;
    pending_results.push_back(r);
  endtask

  task automatic predict_append(bit erase_ok, bit program_ok);
    logic [31:0] sq;
    bit          dirty;
    int unsigned p;
    top_seq = top_seq + 32'd1;
    sq      = top_seq;
    if (wr_page >= PAGES) wr_page = 0;
    // torn page in mid-sector: jump to the next sector boundary
    if ((wr_page % PPS) != 0 && ring_word[wr_page] != EMPTY_WORD)
      wr_page = ((wr_page / PPS + 1) * PPS) % PAGES;
    if ((wr_page % PPS) == 0) begin
      dirty = 1'b0;
      for (p = wr_page; p < wr_page + PPS; p++)
        if (ring_word[p] != EMPTY_WORD) dirty = 1'b1;
      if (dirty) begin
        push_result(OP_ERASE, wr_page / PPS, 32'd0, STAT_DONE, 1'b0);
        if (!erase_ok) begin
          push_result(OP_STATUS, wr_page, sq, STAT_FAIL, 1'b1);
          return;
        end
        for (p = wr_page; p < wr_page + PPS; p++) begin
          if (ring_word[p] != EMPTY_WORD && live_pages > 0) live_pages--;
          ring_word[p] = EMPTY_WORD;
        end
      end
    end
    push_result(OP_PROGRAM, wr_page, sq, STAT_DONE, 1'b0);
    if (!program_ok) begin
      push_result(OP_STATUS, wr_page, sq, STAT_FAIL, 1'b1);
      return;
    end
    p = wr_page;
    ring_word[p] = sq;
    live_pages++;
    wr_page = (wr_page + 1) % PAGES;
    push_result(OP_STATUS, p, sq, STAT_DONE, 1'b1);
  endtask

  task automatic predict_item(item_t it);
    logic [31:0] want;
    int unsigned p;
    bit          found;
    if (it.kind == KIND_SCAN) begin
      p = it.page_index;
      if (ring_word[p] != EMPTY_WORD && live_pages > 0) live_pages--;
      ring_word[p] = it.seq_word;
      if (it.seq_word != EMPTY_WORD) begin
        live_pages++;
        if (it.seq_word > top_seq) begin
          top_seq = it.seq_word;
          wr_page = (p + 1) % PAGES;
        end
      end
      push_result(OP_STATUS, p, it.seq_word, STAT_DONE, 1'b1);
      return;
    end
    if (it.kind > KIND_CLEAR) begin
      push_result(OP_STATUS, 0, 32'd0, STAT_RANGE, 1'b1);
      return;
    end
    if (!log_on) begin
      push_result(OP_STATUS, 0, 32'd0, STAT_UNAVAIL, 1'b1);
      return;
    end
    case (it.kind)
      KIND_EVENT: begin
        if (last_event_ms != 0 && (it.time_ms - last_event_ms) < {16'd0, gap_ms}) begin
          push_result(OP_STATUS, 0, 32'd0, STAT_RATE, 1'b1);
        end else begin
          last_event_ms = (it.time_ms != 0) ? it.time_ms : 32'd1;
          predict_append(it.erase_ok, it.program_ok);
        end
      end
      KIND_BOOT: begin
        predict_append(it.erase_ok, it.program_ok);
      end
      KIND_LOOKUP: begin
        if (it.nth_newest >= live_pages) begin
          push_result(OP_STATUS, 0, 32'd0, STAT_RANGE, 1'b1);
        end else begin
          want  = top_seq - {24'd0, it.nth_newest};
          found = 1'b0;
          for (p = 0; p < PAGES && !found; p++)
            if (ring_word[p] == want) begin
              push_result(OP_STATUS, p, want, STAT_DONE, 1'b1);
              found = 1'b1;
            end
          if (!found) push_result(OP_STATUS, 0, want, STAT_NOT_FOUND, 1'b1);
        end
      end
      default: begin
        // clear: one erase per sector, stops at the first failed erase
        for (p = 0; p < SECTORS; p++) begin
          push_result(OP_ERASE, p, 32'd0, STAT_DONE, 1'b0);
          if (!it.erase_ok) begin
            push_result(OP_STATUS, 0, 32'd0, STAT_FAIL, 1'b1);
            return;
          end
        end
        for (p = 0; p < PAGES; p++) ring_word[p] = EMPTY_WORD;
        live_pages = 0;
        wr_page    = 0;
        top_seq    = 32'd0;
        push_result(OP_STATUS, 0, 32'd0, STAT_DONE, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result checking: every strobe is one transfer, compared with the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_strobe_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result transfer: expected none, actual %p", $time, res_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.op !== want.op) begin
          $display("%0t op: expected %s, actual %0d", $time, want.op.name(), res_o.op);
          fail_count++;
        end
        if (res_o.target !== want.target) begin
          $display("%0t target: expected %0d, actual %0d", $time, want.target, res_o.target);
          fail_count++;
        end
        if (res_o.seq_value !== want.seq_value) begin
          $display("%0t seq_value: expected %h, actual %h", $time, want.seq_value,
                   res_o.seq_value);
          fail_count++;
        end
        if (res_o.status !== want.status) begin
          $display("%0t status: expected %s, actual %0d", $time, want.status.name(),
                   res_o.status);
          fail_count++;
        end
        if (res_o.valid_pages !== want.valid_pages) begin
          $display("%0t valid_pages: expected %0d, actual %0d", $time, want.valid_pages,
                   res_o.valid_pages);
          fail_count++;
        end
        if (res_o.last !== want.last) begin
          $display("%0t last: expected %b, actual %b", $time, want.last, res_o.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog: any input or result transfer counts as progress
  always @(posedge clk_i) begin
    if ((start && !busy) || res_strobe_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  function automatic item_t make_item(logic [2:0] kind, logic [7:0] page, logic [31:0] word,
                                      logic [31:0] ms, logic [7:0] nth, bit eok, bit pok);
    item_t it;
    it.kind       = kind;
    it.page_index = page;
    it.seq_word   = word;
    it.time_ms    = ms;
    it.nth_newest = nth;
    it.erase_ok   = eok;
    it.program_ok = pok;
    return it;
  endfunction

  // holds start high until the transfer; start stays high for a following item unless an idle gap is put in
  task automatic send_item(item_t it);
    in_i  <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_item(it);
    items_sent++;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // every item ends with a status transfer, so an empty queue means the unit is idle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_LOG_AVAILABLE) log_on = value[0];
    else gap_ms = value;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // storage absent after reset: every kind sent is refused, bad kinds as out of range
  task automatic test_unavailable();
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_EVENT, 8'd0, 32'd0, 32'd500, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_LOOKUP, 8'd0, 32'd0, 32'd0, 8'd255, 1'b1, 1'b1));
    send_item(make_item(KIND_CLEAR, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(3'd5, 8'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(3'd6, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1));
    send_item(make_item(3'd7, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b0));
    drain_results();
  endtask

  // failed clear keeps the state, good clear empties every page
  task automatic test_clear();
    write_reg(CFG_LOG_AVAILABLE, 16'd1);
    send_item(make_item(KIND_CLEAR, 8'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1));
    send_item(make_item(KIND_CLEAR, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b0));
    drain_results();
  endtask

  // torn mid-sector page, dirty sector with failed and good erase, failed program
  task automatic test_append();
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b0));
    send_item(make_item(KIND_SCAN, 8'd5, 32'd7, 32'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(KIND_SCAN, 8'd6, 32'd3, 32'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_SCAN, 8'd33, 32'd2, 32'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(KIND_SCAN, 8'd31, 32'd100, 32'd0, 8'd0, 1'b0, 1'b0));
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b0, 1'b1));
    send_item(make_item(KIND_BOOT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    drain_results();
  endtask

  // newest found, deep miss, and beyond the valid count
  task automatic test_lookup();
    send_item(make_item(KIND_LOOKUP, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_LOOKUP, 8'd0, 32'd0, 32'd0, 8'd3, 1'b1, 1'b1));
    send_item(make_item(KIND_LOOKUP, 8'd0, 32'd0, 32'd0, 8'd255, 1'b1, 1'b1));
    drain_results();
  endtask

  // first event at time zero, one inside the gap, one after it
  task automatic test_rate_limit();
    write_reg(CFG_MIN_GAP_MS, 16'd250);
    send_item(make_item(KIND_EVENT, 8'd0, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_EVENT, 8'd0, 32'd0, 32'd10, 8'd0, 1'b1, 1'b1));
    send_item(make_item(KIND_EVENT, 8'd0, 32'd0, 32'd260, 8'd0, 1'b1, 1'b1));
    drain_results();
  endtask

  // sequence words mostly near the current top so lookups and appends interact
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1:       return EMPTY_WORD;
      2, 3, 4, 5: return top_seq + $urandom_range(0, 4) - 32'd2;
      6:          return $urandom;
      7:          return 32'd0;
      default:    return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic item_t pick_item();
    item_t    it;
    int       roll;
    roll = $urandom_range(0, 99);
    it = make_item(KIND_SCAN, 8'($urandom_range(0, 255)), pick_word(), 32'd0,
                   8'($urandom_range(0, 7)), ($urandom_range(0, 7) != 0),
                   ($urandom_range(0, 7) != 0));
    clock_ms = clock_ms + $urandom_range(0, 400);
    it.time_ms = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms;
    if ($urandom_range(0, 4) == 0) it.nth_newest = 8'($urandom_range(0, 255));
    if (roll < 25)      it.kind = KIND_SCAN;
    else if (roll < 45) it.kind = KIND_EVENT;
    else if (roll < 70) it.kind = KIND_BOOT;
    else if (roll < 90) it.kind = KIND_LOOKUP;
    else if (roll < 95) it.kind = KIND_CLEAR;
    else                it.kind = 3'($urandom_range(5, 7));
    return it;
  endfunction

  // random traffic in phases, registers changed between phases while idle
  task automatic test_random();
    int phase;
    int n;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        1: write_reg(CFG_MIN_GAP_MS, 16'd0);
        2: write_reg(CFG_MIN_GAP_MS, 16'hFFFF);
        3: write_reg(CFG_LOG_AVAILABLE, 16'd0);
        4: begin
          write_reg(CFG_LOG_AVAILABLE, 16'hFFFF);
          write_reg(CFG_MIN_GAP_MS, 16'd100);
        end
        5: begin
          write_reg(CFG_MIN_GAP_MS, 16'd250);
          idle_enabled = 1'b0;   // last part runs back to back
        end
        default: ;
      endcase
      for (n = 0; n < ((phase == 3) ? 15 : 39); n++) send_item(pick_item());
      drain_results();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    in_i         = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_LOG_AVAILABLE;
    cfg_data_i   = '0;
    top_seq      = 32'd0;
    wr_page      = 0;
    live_pages   = 0;
    last_event_ms = 32'd0;
    log_on       = 1'b0;
    gap_ms       = MIN_GAP_RESET;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    idle_enabled = 1'b1;
    clock_ms     = 32'd1000;
    for (int p = 0; p < PAGES; p++) ring_word[p] = 32'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unavailable();
    test_clear();
    test_append();
    test_lookup();
    test_rate_limit();
    test_random();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    $display("run covered %0d items and %0d result transfers", items_sent, results_seen);
    $display("scan, event, boot, lookup, clear, bad kinds; erase and program faults");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count,
               pending_results.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/frlpm_pkg.sv
hdl/frlpm_page_store.sv
hdl/flash_ring_log_page_manager_unit.sv
tb/tb_top.sv
